>>> src/sphere_triangle_collision_top_defines.svh
// Assertion macros for the sphere-triangle collision block.
// Included by the top level; uses its clk and arst_n.
`ifndef SPHERE_TRIANGLE_COLLISION_TOP_DEFINES_SVH
`define SPHERE_TRIANGLE_COLLISION_TOP_DEFINES_SVH

// check the consequent in the same cycle
`define STC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check the consequent in the next cycle
`define STC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/stc_pkg.sv
// Shared types and constants of the sphere-triangle collision block.
// No dependencies.
package stc_pkg;
	localparam int COORD_W = 16;
	localparam int NCOORD  = 12;
	localparam int IN_W    = COORD_W * NCOORD;
	localparam int DIF_W   = COORD_W + 1;
	localparam int PRD_W   = 2 * DIF_W;
	localparam int CRS_W   = PRD_W + 1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIF_W-1:0]   dif_t;
	typedef logic signed [PRD_W-1:0]   prd_t;
	typedef logic signed [CRS_W-1:0]   crs_t;

	typedef enum logic [1:0] {
		ST_HIT     = 2'd0,
		ST_FAR     = 2'd1,
		ST_OUTSIDE = 2'd2,
		ST_DEGEN   = 2'd3
	} status_t;
endpackage

>>> src/stc_front.sv
// Front pipeline (three stages): edge differences, cross-product terms,
// face normal and edge cross products. Depends on stc_pkg.
module stc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          ce,
	input  logic                          in_valid,
	input  logic [stc_pkg::IN_W-1:0]      in_data,
	output logic                          valid_s3,
	output stc_pkg::crs_t                 n_s3 [3],
	output stc_pkg::crs_t                 m_s3 [3][3],
	output stc_pkg::dif_t                 q0_s3 [3]
);
	stc_pkg::coord_t crd [stc_pkg::NCOORD];
	stc_pkg::dif_t   a_s1 [4][3];
	stc_pkg::dif_t   b_s1 [4][3];
	stc_pkg::dif_t   q0_s1 [3];
	stc_pkg::dif_t   q0_s2 [3];
	stc_pkg::prd_t   p_s2 [4][3][2];
	stc_pkg::crs_t   c_s3 [4][3];
	logic            valid_s1, valid_s2;

	always_comb begin
		for (int i = 0; i < stc_pkg::NCOORD; i++) begin
			crd[i] = stc_pkg::coord_t'(in_data[stc_pkg::COORD_W*i +: stc_pkg::COORD_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int k = 0; k < 3; k++) begin
				// normal operands: v1-v0 and v2-v0
				a_s1[0][k] <= stc_pkg::dif_t'(crd[6+k]) - stc_pkg::dif_t'(crd[3+k]);
				b_s1[0][k] <= stc_pkg::dif_t'(crd[9+k]) - stc_pkg::dif_t'(crd[3+k]);
				// edges and centre offsets per vertex
				a_s1[1][k] <= stc_pkg::dif_t'(crd[6+k]) - stc_pkg::dif_t'(crd[3+k]);
				b_s1[1][k] <= stc_pkg::dif_t'(crd[k]) - stc_pkg::dif_t'(crd[3+k]);
				a_s1[2][k] <= stc_pkg::dif_t'(crd[9+k]) - stc_pkg::dif_t'(crd[6+k]);
				b_s1[2][k] <= stc_pkg::dif_t'(crd[k]) - stc_pkg::dif_t'(crd[6+k]);
				a_s1[3][k] <= stc_pkg::dif_t'(crd[3+k]) - stc_pkg::dif_t'(crd[9+k]);
				b_s1[3][k] <= stc_pkg::dif_t'(crd[k]) - stc_pkg::dif_t'(crd[9+k]);
				q0_s1[k]   <= stc_pkg::dif_t'(crd[k]) - stc_pkg::dif_t'(crd[3+k]);
			end
			for (int j = 0; j < 4; j++) begin
				for (int k = 0; k < 3; k++) begin
					p_s2[j][k][0] <= a_s1[j][(k+1)%3] * b_s1[j][(k+2)%3];
					p_s2[j][k][1] <= a_s1[j][(k+2)%3] * b_s1[j][(k+1)%3];
					c_s3[j][k] <= stc_pkg::crs_t'(p_s2[j][k][0]) -
						stc_pkg::crs_t'(p_s2[j][k][1]);
				end
			end
			q0_s2 <= q0_s1;
			q0_s3 <= q0_s2;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			n_s3[k] = c_s3[0][k];
			for (int i = 0; i < 3; i++) begin
				m_s3[i][k] = c_s3[i+1][k];
			end
		end
	end
endmodule

>>> src/sphere_triangle_collision_top.sv
// Sphere-triangle collision test, top level: radius register, plane distance,
// inside test and status. Depends on stc_pkg, stc_front and the defines header.
// Throughput: one request per cycle; the eight-stage pipeline advances as a whole
// whenever the output register is empty or being taken.
// Reset: arst_n clears all valid bits and loads radius 1.0 (256).
`include "sphere_triangle_collision_top_defines.svh"
module sphere_triangle_collision_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [15:0]               cfg_wdata,     // sphere_radius
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// center_x/y/z, v0_x/y/z, v1_x/y/z, v2_x/y/z, 16 bits each, lowest first
	input  logic [stc_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [7:0]                m_tdata        // hit [0], status [2:1], zeros
);
	logic          ce;
	logic [15:0]   radius_q;
	logic [31:0]   r2_q;
	logic          valid_s3;
	stc_pkg::crs_t n_s3 [3];
	stc_pkg::crs_t m_s3 [3][3];
	stc_pkg::dif_t q0_s3 [3];

	logic signed [69:0] nsq_s4 [3];
	logic signed [51:0] dp_s4 [3];
	logic signed [69:0] tp_s4 [3][3];
	logic [67:0]        nn_s5;
	logic [53:0]        dabs_s5;
	logic               outside_s5;
	logic [53:0]        hh_s6, hl_s6, ll_s6;
	logic [54:0]        rn_s6 [3];
	logic               degen_s6, outside_s6;
	logic [107:0]       d2_s7, r2n_s7;
	logic               degen_s7, outside_s7;
	logic               v4, v5, v6, v7;
	stc_pkg::status_t   status_s8;

	logic signed [71:0] nn_c, t_c [3];
	logic signed [53:0] d_c;
	logic               pos_c, neg_c;
	logic [22:0]        nn_part [3];
	stc_pkg::status_t   status_c;

	assign ce       = !m_tvalid || m_tready;
	assign s_tready = ce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 16'd256;
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		r2_q <= 32'(radius_q) * 32'(radius_q);
	end

	stc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.ce       (ce),
		.in_valid (s_tvalid),
		.in_data  (s_tdata),
		.valid_s3 (valid_s3),
		.n_s3     (n_s3),
		.m_s3     (m_s3),
		.q0_s3    (q0_s3)
	);

	always_comb begin
		nn_c  = 72'(nsq_s4[0]) + 72'(nsq_s4[1]) + 72'(nsq_s4[2]);
		d_c   = 54'(dp_s4[0]) + 54'(dp_s4[1]) + 54'(dp_s4[2]);
		pos_c = 1'b0;
		neg_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			t_c[i] = 72'(tp_s4[i][0]) + 72'(tp_s4[i][1]) + 72'(tp_s4[i][2]);
			if (t_c[i][71]) begin
				neg_c = 1'b1;
			end else if (t_c[i] != '0) begin
				pos_c = 1'b1;
			end
		end
		nn_part[0] = nn_s5[22:0];
		nn_part[1] = nn_s5[45:23];
		nn_part[2] = {1'b0, nn_s5[67:46]};
		priority if (degen_s7) begin
			status_c = stc_pkg::ST_DEGEN;
		end else if (r2n_s7 < d2_s7) begin
			status_c = stc_pkg::ST_FAR;
		end else if (outside_s7) begin
			status_c = stc_pkg::ST_OUTSIDE;
		end else begin
			status_c = stc_pkg::ST_HIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v4       <= 1'b0;
			v5       <= 1'b0;
			v6       <= 1'b0;
			v7       <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (ce) begin
			v4       <= valid_s3;
			v5       <= v4;
			v6       <= v5;
			v7       <= v6;
			m_tvalid <= v7;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int k = 0; k < 3; k++) begin
				nsq_s4[k] <= 70'(n_s3[k]) * 70'(n_s3[k]);
				dp_s4[k]  <= 52'(q0_s3[k]) * 52'(n_s3[k]);
				for (int i = 0; i < 3; i++) begin
					tp_s4[i][k] <= 70'(m_s3[i][k]) * 70'(n_s3[k]);
				end
			end
			nn_s5      <= nn_c[67:0];
			dabs_s5    <= d_c[53] ? 54'(-d_c) : 54'(d_c);
			outside_s5 <= pos_c && neg_c;
			hh_s6      <= 54'(dabs_s5[53:27]) * 54'(dabs_s5[53:27]);
			hl_s6      <= 54'(dabs_s5[53:27]) * 54'(dabs_s5[26:0]);
			ll_s6      <= 54'(dabs_s5[26:0]) * 54'(dabs_s5[26:0]);
			for (int j = 0; j < 3; j++) begin
				rn_s6[j] <= 55'(r2_q) * 55'(nn_part[j]);
			end
			degen_s6   <= (nn_s5 == '0);
			outside_s6 <= outside_s5;
			d2_s7      <= (108'(hh_s6) << 54) + (108'(hl_s6) << 28) + 108'(ll_s6);
			r2n_s7     <= (108'(rn_s6[2]) << 46) + (108'(rn_s6[1]) << 23) + 108'(rn_s6[0]);
			degen_s7   <= degen_s6;
			outside_s7 <= outside_s6;
			status_s8  <= status_c;
		end
	end

	assign m_tdata = {5'd0, status_s8, (status_s8 == stc_pkg::ST_HIT)};

	`STC_ASSERT_NOW(a_ready_follows_output, 1'b1, s_tready == (!m_tvalid || m_tready), "bad ready")
	`STC_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stall")
	`STC_ASSERT_NOW(a_hit_status, m_tvalid, m_tdata[0] == (m_tdata[2:1] == stc_pkg::ST_HIT), "hit")
	`STC_ASSERT_NEXT(a_drain_valid, ce && v7, m_tvalid, "result lost at output register")
endmodule

>>> tb/testbench.sv
// Testbench for sphere_triangle_collision_top: random and directed sphere/triangle requests,
// predicted with exact wide integer arithmetic and checked through a scoreboard class.
// Depends on stc_pkg and the top level RTL.
`timescale 1ns / 100ps
module testbench;
	typedef logic signed [255:0] wide_t;

	class collision_scoreboard;
		logic [15:0]      radius;
		logic             hit_q[$];
		stc_pkg::status_t status_q[$];
		int               errors;

		function new();
			radius = 16'd256;
			errors = 0;
		endfunction

		function automatic wide_t sx(logic [15:0] v);
			return wide_t'($signed(v));
		endfunction

		function automatic void note_request(logic [stc_pkg::IN_W-1:0] req);
			wide_t c[3], a[3], b[3], e[3];
			wide_t u[3], w[3], n[3], q[3], ed[3], cr[3], t[3], nn, d, r, lhs;
			bit pos, neg;
			stc_pkg::status_t st;
			pos = 0;
			neg = 0;
			for (int i = 0; i < 3; i++) begin
				c[i] = sx(req[16*i +: 16]);
				a[i] = sx(req[16*(3+i) +: 16]);
				b[i] = sx(req[16*(6+i) +: 16]);
				e[i] = sx(req[16*(9+i) +: 16]);
				u[i] = b[i] - a[i];
				w[i] = e[i] - a[i];
			end
			n[0] = u[1]*w[2] - u[2]*w[1];
			n[1] = u[2]*w[0] - u[0]*w[2];
			n[2] = u[0]*w[1] - u[1]*w[0];
			nn = n[0]*n[0] + n[1]*n[1] + n[2]*n[2];
			d = (c[0]-a[0])*n[0] + (c[1]-a[1])*n[1] + (c[2]-a[2])*n[2];
			r = wide_t'({1'b0, radius});
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 3; i++) begin
					case (k)
						0: begin ed[i] = b[i] - a[i]; q[i] = c[i] - a[i]; end
						1: begin ed[i] = e[i] - b[i]; q[i] = c[i] - b[i]; end
						default: begin ed[i] = a[i] - e[i]; q[i] = c[i] - e[i]; end
					endcase
				end
				cr[0] = ed[1]*q[2] - ed[2]*q[1];
				cr[1] = ed[2]*q[0] - ed[0]*q[2];
				cr[2] = ed[0]*q[1] - ed[1]*q[0];
				t[k] = cr[0]*n[0] + cr[1]*n[1] + cr[2]*n[2];
				if (t[k] > 0) pos = 1;
				if (t[k] < 0) neg = 1;
			end
			lhs = r*r*nn - d*d;
			if (nn == 0) st = stc_pkg::ST_DEGEN;
			else if (lhs < 0) st = stc_pkg::ST_FAR;
			else if (pos && neg) st = stc_pkg::ST_OUTSIDE;
			else st = stc_pkg::ST_HIT;
			hit_q.push_back(st == stc_pkg::ST_HIT);
			status_q.push_back(st);
		endfunction

		function automatic void check_result(logic [7:0] res);
			if (hit_q.size() == 0) begin
				$error("result with no request pending: %h", res);
				errors++;
				return;
			end
			if (res[0] !== hit_q[0]) begin
				$error("hit expected %0d actual %0d", hit_q[0], res[0]);
				errors++;
			end
			if (res[2:1] !== status_q[0]) begin
				$error("status expected %0d actual %0d", status_q[0], res[2:1]);
				errors++;
			end
			if (res[7:3] !== 5'd0) begin
				$error("pad expected 0 actual %h", res[7:3]);
				errors++;
			end
			void'(hit_q.pop_front());
			void'(status_q.pop_front());
		endfunction
	endclass

	logic                     clk, arst_n, cfg_we, s_tvalid, s_tready, m_tvalid, m_tready;
	logic [15:0]              cfg_wdata;
	logic [stc_pkg::IN_W-1:0] s_tdata;
	logic [7:0]               m_tdata;
	int                       send_idle, recv_idle;
	collision_scoreboard      sb;

	sphere_triangle_collision_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("sphere_triangle_collision_top test failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
		if (arst_n) m_tready <= ($urandom_range(99) >= recv_idle);
	end

	function automatic logic [15:0] pick_coord();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3, 4: return 16'($urandom);
			default: return 16'($signed($urandom_range(2048)) - 1024);
		endcase
	endfunction

	task automatic send_request(logic [stc_pkg::IN_W-1:0] req);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata  <= req;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_request(req);
	endtask

	task automatic random_request();
		logic [stc_pkg::IN_W-1:0] req;
		logic [15:0] vtx[9];
		for (int i = 0; i < 9; i++) vtx[i] = pick_coord();
		case ($urandom_range(5))
			0: begin
				vtx[6] = vtx[0]; vtx[7] = vtx[1]; vtx[8] = vtx[2];
			end
			1: begin
				vtx[6] = 16'(2*vtx[3] - vtx[0]); vtx[7] = 16'(2*vtx[4] - vtx[1]);
				vtx[8] = 16'(2*vtx[5] - vtx[2]);
			end
			default: ;
		endcase
		req[47:0] = {pick_coord(), pick_coord(), pick_coord()};
		if ($urandom_range(2) == 0)
			for (int i = 0; i < 3; i++)
				req[16*i +: 16] = 16'(($signed(vtx[i]) + $signed(vtx[3+i])
					+ $signed(vtx[6+i])) / 3 + $signed($urandom_range(64)) - 32);
		for (int i = 0; i < 9; i++) req[16*(3+i) +: 16] = vtx[i];
		send_request(req);
	endtask

	task automatic drain_and_set(logic [15:0] rad);
		s_tvalid <= 0;
		@(posedge clk);
		while (sb.hit_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		cfg_we    <= 1;
		cfg_wdata <= rad;
		@(posedge clk);
		cfg_we <= 0;
		sb.radius = rad;
	endtask

	initial begin
		logic [15:0] radii[6];
		sb = new();
		arst_n = 0; cfg_we = 0; cfg_wdata = 0; s_tvalid = 0; s_tdata = 0; m_tready = 0;
		send_idle = 18; recv_idle = 59;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// touching, just clear, edge, vertex, outside, degenerate, extremes at reset radius
		send_request({16'h0000,16'h0100,16'h0000, 16'h0000,16'h0000,16'h0100,
			16'h0000,16'h0000,16'h0000, 16'h0100,16'h0000,16'h0000});
		send_request({16'h0000,16'h0100,16'h0000, 16'h0000,16'h0000,16'h0100,
			16'h0000,16'h0000,16'h0000, 16'h0101,16'h0000,16'h0000});
		send_request({16'h0000,16'h0100,16'h0000, 16'h0000,16'h0000,16'h0100,
			16'h0000,16'h0000,16'h0000, 16'h0000,16'h0080,16'h0080});
		send_request({16'h0000,16'h0100,16'h0000, 16'h0000,16'h0000,16'h0100,
			16'h0000,16'h0000,16'h0000, 16'h0000,16'h0000,16'h0000});
		send_request({16'h0000,16'h0100,16'h0000, 16'h0000,16'h0000,16'h0100,
			16'h0000,16'h0000,16'h0000, 16'h0000,16'h0200,16'h0200});
		send_request({16'h0200,16'h0200,16'h0200, 16'h0100,16'h0100,16'h0100,
			16'h0000,16'h0000,16'h0000, 16'h0000,16'h0000,16'h0000});
		send_request({16'h7fff,16'h8000,16'h7fff, 16'h8000,16'h7fff,16'h8000,
			16'h8000,16'h8000,16'h8000, 16'h7fff,16'h7fff,16'h7fff});
		send_request({16'h8000,16'h7fff,16'h8000, 16'h8000,16'h8000,16'h7fff,
			16'h7fff,16'h8000,16'h8000, 16'h0000,16'h0000,16'h0000});
		send_request({16'hffff,16'h0000,16'h0000, 16'h0000,16'hffff,16'h0000,
			16'h0000,16'h0000,16'hffff, 16'h0000,16'h0000,16'h0000});

		radii = '{16'h0000, 16'hffff, 16'h0001, 16'h0400, 16'h1000, 16'h0100};
		for (int ph = 0; ph < 6; ph++) begin
			drain_and_set(radii[ph]);
			if (ph == 2) begin send_idle = 59; recv_idle = 18; end
			if (ph == 4) begin send_idle = 0; recv_idle = 0; end
			for (int i = 0; i < 330; i++) begin
				if (ph != 0 && ph != 2 && ph != 4 && $urandom_range(3) == 0)
					drain_and_set(16'($urandom));
				random_request();
			end
		end

		s_tvalid <= 0;
		@(posedge clk);
		while (sb.hit_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("sphere_triangle_collision_top test passed");
		else
			$display("sphere_triangle_collision_top test failed");
		$finish;
	end
endmodule

>>> sphere_triangle_collision_top.f
+incdir+src
src/stc_pkg.sv
src/stc_front.sv
src/sphere_triangle_collision_top.sv
tb/testbench.sv
